// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert macros
// concurrent assertion helpers shared by the rtl, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gmf_pkg.sv =====
// ----------------------------------------------------------------------------
// gmf_pkg
// types and constants of the gated range median fusion block
// ----------------------------------------------------------------------------
package gmf_pkg;

   localparam int FUNC_W     = 3;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int LEN_CMP_W  = 7;

   localparam logic [FUNC_W-1:0] CH_LONG_IR    = 3'd0;
   localparam logic [FUNC_W-1:0] CH_SHORT_IR_A = 3'd1;
   localparam logic [FUNC_W-1:0] CH_SHORT_IR_B = 3'd2;
   localparam logic [FUNC_W-1:0] CH_US_LEFT    = 3'd3;
   localparam logic [FUNC_W-1:0] CH_US_RIGHT   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_IR_THR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_IR_THR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ULTRASONIC_THR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH   = 3'd4;

   localparam logic [SAMPLE_W-1:0] LONG_IR_FLOOR  = 16'd320;
   localparam logic [SAMPLE_W-1:0] SHORT_IR_FLOOR = 16'd128;
   localparam logic [SAMPLE_W-1:0] JUMP_LIMIT     = 16'd496;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_MED_RD,
      ST_MED_OUT
   } gmf_state_type;

endpackage

// ===== rtl/core/gmf_ram.sv =====
// ----------------------------------------------------------------------------
// gmf_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gated_range_median_fusion.sv =====
// ----------------------------------------------------------------------------
// gated_range_median_fusion
// gated, conditioned range samples of five sensors, median per window
// ----------------------------------------------------------------------------
// usage
//   an item (req_func, req_sample_value) is taken on a clock edge with start
//   high and busy low. disabled channels, unknown codes and ir jumps are
//   dropped at once and busy stays low. a kept item is insertion sorted into
//   the window ram, one ram read and one write per cycle, and this sorted insert
//   through the single write port sets how long busy stays high. when the window
//   is full the ST_MED_RD state reads the middle entry, then ST_MED_OUT strobes
//   rsp_valid one cycle with rsp_median_value.
//   the receiver cannot stall: the result is shown for exactly one cycle.
//   csr_write with csr_index and csr_data writes a register; the user must
//   write only while idle, the block itself does not enforce it.
//   reset (synchronous) restores register defaults, empties the window and
//   clears both ir last values; the ram needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gated_range_median_fusion
   import gmf_pkg::*;
#(
   parameter int MAX_WINDOW = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [SAMPLE_W-1:0]   req_sample_value,
   output logic                  rsp_valid,
   output logic [SAMPLE_W-1:0]   rsp_median_value,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = $clog2(MAX_WINDOW + 1);

   gmf_state_type       state_ff, state_in;
   logic [4:0]          chan_en_ff;
   logic [7:0]          lir_thr_ff, sir_thr_ff, us_thr_ff;
   logic [5:0]          win_len_ff;
   logic [CW-1:0]       fill_ff, fill_in, fill_new;
   logic [SAMPLE_W-1:0] last_lir_ff, last_sir_ff;
   logic [AW-1:0]       hole_ff, hole_in, hole_m1, hole_m2;
   logic [SAMPLE_W-1:0] val_ff, val_in;

   logic                accept, chan_on, is_lir, is_sir, below, keep, keep_item;
   logic [7:0]          sel_thr, chan_en_ext;
   logic [SAMPLE_W-1:0] thr_q4, whole, sel_last, diff, stored;
   logic [LEN_CMP_W-1:0] wl_ext, len_eff;
   logic                complete;

   logic                mem_we;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [SAMPLE_W-1:0] mem_wr_data, mem_rd_data;

   gmf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sample conditioning
   assign accept      = start && !busy;
   assign chan_en_ext = {3'b000, chan_en_ff};
   assign chan_on     = (req_func <= CH_US_RIGHT) && chan_en_ext[req_func];
   assign is_lir      = (req_func == CH_LONG_IR);
   assign is_sir      = (req_func == CH_SHORT_IR_A) || (req_func == CH_SHORT_IR_B);
   assign sel_thr     = is_lir ? lir_thr_ff : (is_sir ? sir_thr_ff : us_thr_ff);
   assign thr_q4      = {4'b0000, sel_thr, 4'b0000};
   assign below       = (req_sample_value < thr_q4);
   assign whole       = {req_sample_value[SAMPLE_W-1:4], 4'b0000};
   assign sel_last    = is_lir ? last_lir_ff : last_sir_ff;
   assign diff        = (sel_last >= whole) ? (sel_last - whole) : (whole - sel_last);

   always_comb begin
      if (is_lir || is_sir) begin
         stored = below ? (is_lir ? LONG_IR_FLOOR : SHORT_IR_FLOOR) : req_sample_value;
         keep   = below || (diff < JUMP_LIMIT);
      end else begin
         stored = below ? thr_q4 : req_sample_value;
         keep   = 1'b1;
      end
   end

   // only looked at while idle, where busy is low
   assign keep_item = start && chan_on && keep;

   // effective window length
   assign wl_ext   = {1'b0, win_len_ff};
   assign len_eff  = (win_len_ff == 6'd0) ? LEN_CMP_W'(1) :
                     ((wl_ext > LEN_CMP_W'(MAX_WINDOW)) ? LEN_CMP_W'(MAX_WINDOW) : wl_ext);
   assign fill_new = fill_ff + CW'(1);
   assign complete = (LEN_CMP_W'(fill_new) >= len_eff);

   assign hole_m1 = hole_ff - AW'(1);
   assign hole_m2 = hole_m1 - AW'(1);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      hole_in     = hole_ff;
      val_in      = val_ff;
      mem_we      = 1'b0;
      mem_wr_addr = hole_ff;
      mem_wr_data = val_ff;
      mem_rd_addr = hole_m1;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (keep_item) begin
               state_in = ST_INS_RD;
               hole_in  = fill_ff[AW-1:0];
               val_in   = stored;
            end
         end
         ST_INS_RD: begin
            if (hole_ff == '0) begin
               mem_we = 1'b1;
               if (complete) begin
                  state_in = ST_MED_RD;
               end else begin
                  fill_in  = fill_new;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            mem_we = 1'b1;
            if (mem_rd_data > val_ff) begin
               mem_wr_data = mem_rd_data;
               hole_in     = hole_m1;
               mem_rd_addr = hole_m2;
               if (hole_m1 == '0) begin
                  state_in = ST_INS_RD;
               end
            end else if (complete) begin
               state_in = ST_MED_RD;
            end else begin
               fill_in  = fill_new;
               state_in = ST_IDLE;
            end
         end
         ST_MED_RD: begin
            mem_rd_addr = AW'(fill_ff >> 1);
            state_in    = ST_MED_OUT;
         end
         ST_MED_OUT: begin
            rsp_valid = 1'b1;
            fill_in   = '0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_median_value = mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         last_lir_ff <= '0;
         last_sir_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (accept && chan_on && is_lir) begin
            last_lir_ff <= req_sample_value;
         end
         if (accept && chan_on && is_sir) begin
            last_sir_ff <= req_sample_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      val_ff  <= val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_en_ff <= 5'd31;
         lir_thr_ff <= 8'd20;
         sir_thr_ff <= 8'd8;
         us_thr_ff  <= 8'd20;
         win_len_ff <= 6'd7;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHANNEL_ENABLE: chan_en_ff <= csr_data[4:0];
            CSR_LONG_IR_THR:    lir_thr_ff <= csr_data;
            CSR_SHORT_IR_THR:   sir_thr_ff <= csr_data;
            CSR_ULTRASONIC_THR: us_thr_ff  <= csr_data;
            CSR_WINDOW_LENGTH:  win_len_ff <= csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   // checks
   `ASSERT_NEXT(a_result_empties_window, clock, reset, rsp_valid, !busy && (fill_ff == '0), "window not emptied after result")
   `ASSERT_IMPLY(a_window_in_range, clock, reset, 1'b1, fill_ff < CW'(MAX_WINDOW), "window fill out of range")
   `ASSERT_IMPLY(a_compare_hole_nonzero, clock, reset, state_ff == ST_INS_CMP, hole_ff != '0, "compare step at bottom entry")
   `ASSERT_IMPLY(a_result_after_read, clock, reset, rsp_valid, $past(state_ff) == ST_MED_RD, "result without median read")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gated range median fusion block: items from the
// five range channels are driven through the start/busy handshake, a
// scoreboard conditions and windows each accepted item on its own and checks
// every median strobe, over several register settings and idle patterns
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gmf_pkg::*;

   localparam int MAX_WINDOW     = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = MAX_WINDOW + 8;
   localparam int SEGMENTS       = 12;
   localparam int SEGMENT_ITEMS  = 47;

   class median_scoreboard;
      logic [4:0]          chan_en;
      logic [7:0]          long_thr;
      logic [7:0]          short_thr;
      logic [7:0]          us_thr;
      logic [5:0]          win_len;
      logic [SAMPLE_W-1:0] window [MAX_WINDOW];
      int unsigned         fill;
      logic [SAMPLE_W-1:0] last_long;
      logic [SAMPLE_W-1:0] last_short;
      logic [SAMPLE_W-1:0] medians_due [$];
      int unsigned         errors;
      int unsigned         compared;

      function new();
         chan_en    = 5'd31;
         long_thr   = 8'd20;
         short_thr  = 8'd8;
         us_thr     = 8'd20;
         win_len    = 6'd7;
         fill       = 0;
         last_long  = '0;
         last_short = '0;
         errors     = 0;
         compared   = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_CHANNEL_ENABLE: chan_en = val[4:0];
            CSR_LONG_IR_THR:    long_thr = val;
            CSR_SHORT_IR_THR:   short_thr = val;
            CSR_ULTRASONIC_THR: us_thr = val;
            CSR_WINDOW_LENGTH:  win_len = val[5:0];
            default: ;
         endcase
      endfunction

      // below threshold gives the floor, a jump of 31 cm or more is dropped
      function bit condition_ir(input logic [SAMPLE_W-1:0] s, input logic [7:0] thr,
                                input logic [SAMPLE_W-1:0] floor_v,
                                inout logic [SAMPLE_W-1:0] last,
                                output logic [SAMPLE_W-1:0] stored);
         logic [SAMPLE_W-1:0] whole;
         logic [SAMPLE_W-1:0] diff;
         whole  = s & 16'hFFF0;
         diff   = (last >= whole) ? last - whole : whole - last;
         last   = s;
         stored = s;
         if (s < {4'h0, thr, 4'h0}) begin
            stored = floor_v;
            return 1'b1;
         end
         return diff < JUMP_LIMIT;
      endfunction

      function logic [SAMPLE_W-1:0] window_median(int unsigned count);
         logic [SAMPLE_W-1:0] sorted [MAX_WINDOW];
         logic [SAMPLE_W-1:0] v;
         int unsigned j;
         sorted = window;
         for (int unsigned i = 1; i < count; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
         end
         return sorted[(count - 1) / 2];
      endfunction

      function void note_item(logic [FUNC_W-1:0] f, logic [SAMPLE_W-1:0] s);
         logic [SAMPLE_W-1:0] stored;
         bit                  keep;
         int unsigned         len;
         if (f > CH_US_RIGHT) return;
         if (!chan_en[f]) return;
         if (f == CH_LONG_IR) begin
            keep = condition_ir(s, long_thr, LONG_IR_FLOOR, last_long, stored);
         end else if (f == CH_SHORT_IR_A || f == CH_SHORT_IR_B) begin
            keep = condition_ir(s, short_thr, SHORT_IR_FLOOR, last_short, stored);
         end else begin
            stored = (s < {4'h0, us_thr, 4'h0}) ? {4'h0, us_thr, 4'h0} : s;
            keep   = 1'b1;
         end
         if (!keep) return;
         len = win_len;
         if (len == 0) len = 1;
         if (len > MAX_WINDOW) len = MAX_WINDOW;
         if (fill < MAX_WINDOW) begin
            window[fill] = stored;
            fill++;
         end
         if (fill >= len) begin
            medians_due = {medians_due, window_median(fill)};
            fill = 0;
         end
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_median(logic [SAMPLE_W-1:0] got);
         logic [SAMPLE_W-1:0] want;
         compared++;
         if (medians_due.size() == 0) begin
            report($sformatf("median 0x%04h with none expected", got));
         end else begin
            want = medians_due.pop_front();
            if (got !== want)
               report($sformatf("median_value 0x%04h, expected 0x%04h", got, want));
         end
      endtask

      function int pending();
         return medians_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [SAMPLE_W-1:0]   req_sample_value = '0;
   logic                  rsp_valid;
   logic [SAMPLE_W-1:0]   rsp_median_value;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   median_scoreboard sb = new();
   int unsigned      accepted = 0;
   int unsigned      settings = 0;
   int unsigned      stall_cycles = 0;
   int unsigned      idle_pct = 0;
   logic [SAMPLE_W-1:0] aim_long = '0;
   logic [SAMPLE_W-1:0] aim_short = '0;

   gated_range_median_fusion #(
      .MAX_WINDOW(MAX_WINDOW)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_sample_value(req_sample_value),
      .rsp_valid(rsp_valid),
      .rsp_median_value(rsp_median_value),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid) sb.check_median(rsp_median_value);
         if (start && !busy) begin
            sb.note_item(req_func, req_sample_value);
            accepted++;
         end
         if (rsp_valid || (start && !busy)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item or median for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic program_regs(input logic [7:0] en, input logic [7:0] lthr,
                               input logic [7:0] sthr, input logic [7:0] uthr,
                               input logic [7:0] wlen);
      logic [CSR_IDX_W-1:0]  idx  [5];
      logic [CSR_DATA_W-1:0] vals [5];
      idx  = '{CSR_CHANNEL_ENABLE, CSR_LONG_IR_THR, CSR_SHORT_IR_THR,
               CSR_ULTRASONIC_THR, CSR_WINDOW_LENGTH};
      vals = '{en, lthr, sthr, uthr, wlen};
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         @(posedge clock);
         sb.set_reg(idx[i], vals[i]);
      end
      csr_write <= 1'b0;
      settings++;
   endtask

   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] s);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start            <= 1'b1;
      req_func         <= f;
      req_sample_value <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold off until all medians are in, then let a pending insert finish
   task automatic drain();
      start <= 1'b0;
      for (int n = 0; n < 2000 && sb.pending() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] near_value(logic [SAMPLE_W-1:0] aim);
      int v;
      v = int'(aim) + int'($urandom_range(1040)) - 520;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic [SAMPLE_W-1:0] ir_value(logic [SAMPLE_W-1:0] aim,
                                                    logic [7:0] thr);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15 && thr != 0) return SAMPLE_W'($urandom_range({thr, 4'h0} - 1));
      if (r < 30) return SAMPLE_W'($urandom_range(16'hFFFF));
      return near_value(aim);
   endfunction

   task automatic send_random();
      int unsigned         r;
      logic [FUNC_W-1:0]   f;
      logic [SAMPLE_W-1:0] s;
      r = $urandom_range(99);
      if (r < 6) begin
         f = FUNC_W'($urandom_range(7, CH_US_RIGHT + 1));
         s = SAMPLE_W'($urandom_range(16'hFFFF));
      end else if (r < 36) begin
         f = CH_LONG_IR;
         s = ir_value(aim_long, sb.long_thr);
         aim_long = s;
      end else if (r < 66) begin
         f = $urandom_range(1) ? CH_SHORT_IR_A : CH_SHORT_IR_B;
         s = ir_value(aim_short, sb.short_thr);
         aim_short = s;
      end else begin
         f = $urandom_range(1) ? CH_US_LEFT : CH_US_RIGHT;
         if ($urandom_range(99) < 30 && sb.us_thr != 0)
            s = SAMPLE_W'($urandom_range({sb.us_thr, 4'h0} - 1));
         else
            s = SAMPLE_W'($urandom_range(16'hFFFF));
      end
      send_item(f, s);
   endtask

   initial begin
      logic [7:0] wlen;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: floors, jump drops at the edge, ignored codes
      send_item(CH_LONG_IR, 16'h0000);
      send_item(CH_LONG_IR, 16'hFFFF);
      send_item(CH_LONG_IR, 16'hFE20);
      send_item(CH_LONG_IR, 16'hFC00);
      send_item(CH_SHORT_IR_A, 16'd127);
      send_item(CH_SHORT_IR_B, 16'd128);
      send_item(CH_SHORT_IR_B, 16'd624);
      send_item(CH_SHORT_IR_A, 16'd1119);
      send_item(CH_US_LEFT, 16'd319);
      send_item(CH_US_RIGHT, 16'hFFFF);
      send_item(CH_US_RIGHT + 3'd1, 16'h5555);
      send_item(CH_US_RIGHT + 3'd2, 16'hAAAA);
      send_item(CH_US_RIGHT + 3'd3, 16'h1234);
      drain();

      // disabled channels, then a window shortened below its fill
      program_regs(8'b10101, 8'd1, 8'd2, 8'd3, 8'd20);
      send_item(CH_SHORT_IR_A, 16'd2000);
      send_item(CH_US_LEFT, 16'd2000);
      for (int i = 0; i < 6; i++) send_item(CH_US_RIGHT, SAMPLE_W'(40 + 700 * i));
      drain();
      program_regs(8'd31, 8'd20, 8'd8, 8'd20, 8'd2);
      send_item(CH_US_LEFT, 16'd0);
      drain();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         idle_pct = (seg < 4) ? 27 : (seg < 8) ? 80 : 0;
         case (seg % 4)
            0: program_regs(8'd31, 8'd0, 8'd0, 8'd0, 8'd1);
            1: program_regs(8'd31, 8'd255, 8'd255, 8'd255, 8'd32);
            2: program_regs(8'd31, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'd0);
            default: begin
               wlen = ($urandom_range(3) == 0) ? 8'($urandom_range(63))
                                               : 8'($urandom_range(1, 9));
               program_regs(8'($urandom_range(31)), 8'($urandom_range(40)),
                            8'($urandom_range(40)), 8'($urandom_range(40)), wlen);
            end
         endcase
         for (int i = 0; i < SEGMENT_ITEMS; i++) send_random();
         drain();
      end

      idle_pct = 0;
      program_regs(8'd31, 8'd20, 8'd8, 8'd20, 8'd63);
      for (int i = 0; i < 2 * MAX_WINDOW; i++) send_random();
      drain();

      if (sb.pending() != 0)
         sb.report($sformatf("%0d medians never arrived", sb.pending()));
      $display("run covered %0d items over %0d register settings", accepted, settings);
      $display("%0d medians compared, %0d mismatches", sb.compared, sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
